// ===== sv/pdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg: shared types, widths and tables of the planar dead-reckoning block
// Holds the CORDIC arctangent table, the Q15 rounding helper, the sequencer
// state type and the control struct of the shared multiplier.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // CORDIC length, capped by the size of the arctangent table
  localparam int TRIG_BITS    = 16;
  localparam int ATAN_DEPTH   = 24;
  localparam int CORDIC_ITERS = (TRIG_BITS < ATAN_DEPTH) ? TRIG_BITS : ATAN_DEPTH;
  localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);
  localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

  // field widths
  localparam int ANGLE_W = 19;
  localparam int ALT_W   = 17;
  localparam int TIME_W  = 32;
  localparam int VEL_W   = 16;
  localparam int FST_W   = 4;
  localparam int POS_W   = 48;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 176;

  // CORDIC datapath
  localparam int WRAP_W = ANGLE_W + 1;
  localparam int CXY_W  = 34;
  localparam int CZ_W   = 32;
  localparam int TRIG_W = 16;
  localparam logic signed [CXY_W-1:0]  CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [WRAP_W-1:0] FULL_TURN    = 20'sd360000;
  localparam logic signed [WRAP_W-1:0] HALF_TURN    = 20'sd180000;
  localparam logic signed [WRAP_W-1:0] QUARTER_TURN = 20'sd90000;
  localparam logic signed [CXY_W-1:0]  Q15_HALF     = 34'sd16384;
  localparam logic signed [CXY_W-1:0]  Q15_MAX      = 34'sd32767;

  // shared multiplier and accumulator
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 66;
  localparam int HALF_SH = 16;
  localparam int DISP_W  = ACC_W - 15;
  localparam int SUM_W   = 52;
  localparam logic signed [ACC_W-1:0] DISP_HALF = 66'sd16384;
  localparam logic signed [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [TIME_W-1:0] MAX_STEP_RESET = 32'd1000000;

  // multiplier sequence steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CVX  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SVY  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SVX  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CVY  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_GXL  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_GXH  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_GYL  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_GYH  = 4'd7;
  localparam logic [STEP_W-1:0] CAP_GX    = 4'd3;
  localparam logic [STEP_W-1:0] CAP_GY    = 4'd5;
  localparam logic [STEP_W-1:0] CAP_PX    = 4'd7;
  localparam logic [STEP_W-1:0] CAP_PY    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_ACC
  } pdr_state_t;

  typedef struct packed {
    logic vld;  // product enters the accumulator
    logic clr;  // start a new sum
    logic neg;  // subtract the term
    logic hi;   // term weighted by 2^16
  } mul_ctl_t;

  // atan(2^-i) in millidegrees times 4096
  function automatic logic signed [CZ_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd184320000;
      5'd1:    v = 32'sd108810450;
      5'd2:    v = 32'sd57492453;
      5'd3:    v = 32'sd29184067;
      5'd4:    v = 32'sd14648666;
      5'd5:    v = 32'sd7331474;
      5'd6:    v = 32'sd3666632;
      5'd7:    v = 32'sd1833428;
      5'd8:    v = 32'sd916728;
      5'd9:    v = 32'sd458366;
      5'd10:   v = 32'sd229183;
      5'd11:   v = 32'sd114592;
      5'd12:   v = 32'sd57296;
      5'd13:   v = 32'sd28648;
      5'd14:   v = 32'sd14324;
      5'd15:   v = 32'sd7162;
      5'd16:   v = 32'sd3581;
      5'd17:   v = 32'sd1790;
      5'd18:   v = 32'sd895;
      5'd19:   v = 32'sd448;
      5'd20:   v = 32'sd224;
      5'd21:   v = 32'sd112;
      5'd22:   v = 32'sd56;
      5'd23:   v = 32'sd28;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q30 -> Q15, round half up, clamp to +/-32767
  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CXY_W-1:0] v);
    logic signed [CXY_W-1:0] r;
    r = (v + Q15_HALF) >>> 15;
    if (r > Q15_MAX) begin
      r = Q15_MAX;
    end else if (r < -Q15_MAX) begin
      r = -Q15_MAX;
    end
    return TRIG_W'(r);
  endfunction

endpackage

// ===== sv/planar_dead_reckoning_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_dead_reckoning_integrator: X/Y dead reckoning from yaw and velocity
// Rotates body velocity by yaw, scales by the time step and accumulates a
// saturating global position in nanometres.
// ----------------------------------------------------------------------------
// One navigation sample is taken at a time. Once a transaction is accepted on
// the input, in_tready stays low until the result is written to the output
// register. The sample is accepted, then the iterative CORDIC runs (one
// micro-rotation per cycle, at the default length of 16), then the single
// shared 33x17 multiplier forms four products for the rotation and four for
// the time scaling and then drains, and finally the saturating accumulate
// runs. The output register lets the block take the next sample while the
// previous result still waits on out_tready; a finished result then holds
// in the accumulate step until the output register is free. The time step
// is the timestamp difference modulo 2^32, clamped to max_step_us; the first
// sample after reset moves nothing. max_step_us is written through
// cfg_we/cfg_wdata and resets to 1000000; the user must write it only while
// the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module planar_dead_reckoning_integrator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // roll_mdeg[18:0], pitch_mdeg[37:19], yaw_mdeg[56:38], altitude_mm[73:57],
  // time_us[105:74], vel_x[121:106], vel_y[137:122], flight_state[141:138]
  input  logic [pdr_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // pos_x_nm[47:0], pos_y_nm[95:48], height_mm[112:96], roll_out[131:113],
  // pitch_out[150:132], yaw_out[169:151], state_out[173:170], saturated[174]
  output logic [pdr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [pdr_pkg::TIME_W-1:0]           cfg_wdata
);

  pdr_pkg::pdr_state_t state_r, state_nxt;
  logic [pdr_pkg::STEP_W-1:0] step_r, step_nxt;

  // configuration and time tracking
  logic [pdr_pkg::TIME_W-1:0] max_step_r;
  logic [pdr_pkg::TIME_W-1:0] last_time_r;
  logic                       started_r;
  logic [pdr_pkg::TIME_W-1:0] diff_r;
  logic [pdr_pkg::TIME_W-1:0] dt_r;

  // sample held for the duration of the transaction
  logic [pdr_pkg::ANGLE_W-1:0]       roll_r, pitch_r, yaw_r;
  logic [pdr_pkg::ALT_W-1:0]         alt_r;
  logic [pdr_pkg::FST_W-1:0]         fst_r;
  logic signed [pdr_pkg::VEL_W-1:0]  vx_r, vy_r;

  // intermediate results
  logic signed [pdr_pkg::MUL_A_W-1:0] gx_r, gy_r;
  logic signed [pdr_pkg::ACC_W-1:0]   px_r, py_r;
  logic signed [pdr_pkg::POS_W-1:0]   pos_x_r, pos_y_r;

  logic [pdr_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                            out_valid_r;

  // control outputs of the sequencer
  logic accept, cor_start, out_load;
  logic cap_gx, cap_gy, cap_px, cap_py, dt_upd;
  pdr_pkg::mul_ctl_t                  mul_ctl;
  logic signed [pdr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pdr_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pdr_pkg::ACC_W-1:0]   mul_acc;

  logic                              cor_done;
  logic signed [pdr_pkg::TRIG_W-1:0] cos_q15, sin_q15;

  // displacement and saturating sums
  logic signed [pdr_pkg::DISP_W-1:0] disp_x, disp_y;
  logic signed [pdr_pkg::SUM_W-1:0]  sum_x, sum_y;
  logic signed [pdr_pkg::POS_W-1:0]  new_x, new_y;
  logic                              sat_x, sat_y;

  pdr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .yaw     ($signed(in_tdata[56:38])),
    .done    (cor_done),
    .cos_q15 (cos_q15),
    .sin_q15 (sin_q15)
  );

  pdr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .acc   (mul_acc)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      pdr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = pdr_pkg::ST_ROT;
        end
      end
      pdr_pkg::ST_ROT: begin
        step_nxt = '0;
        if (cor_done) begin
          state_nxt = pdr_pkg::ST_MUL;
        end
      end
      pdr_pkg::ST_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == pdr_pkg::STEP_LAST) begin
          state_nxt = pdr_pkg::ST_ACC;
        end
      end
      pdr_pkg::ST_ACC: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          state_nxt = pdr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pdr_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    dt_upd    = 1'b0;
    cap_gx    = 1'b0;
    cap_gy    = 1'b0;
    cap_px    = 1'b0;
    cap_py    = 1'b0;
    mul_ctl   = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      pdr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      pdr_pkg::ST_ROT: begin
        dt_upd = 1'b1;
      end
      pdr_pkg::ST_MUL: begin
        cap_gx = (step_r == pdr_pkg::CAP_GX);
        cap_gy = (step_r == pdr_pkg::CAP_GY);
        cap_px = (step_r == pdr_pkg::CAP_PX);
        cap_py = (step_r == pdr_pkg::CAP_PY);
        case (step_r)
          pdr_pkg::STEP_CVX: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
            mul_a   = pdr_pkg::MUL_A_W'(cos_q15);
            mul_b   = pdr_pkg::MUL_B_W'(vx_r);
          end
          pdr_pkg::STEP_SVY: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
            mul_a   = pdr_pkg::MUL_A_W'(sin_q15);
            mul_b   = pdr_pkg::MUL_B_W'(vy_r);
          end
          pdr_pkg::STEP_SVX: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
            mul_a   = pdr_pkg::MUL_A_W'(sin_q15);
            mul_b   = pdr_pkg::MUL_B_W'(vx_r);
          end
          pdr_pkg::STEP_CVY: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b0};
            mul_a   = pdr_pkg::MUL_A_W'(cos_q15);
            mul_b   = pdr_pkg::MUL_B_W'(vy_r);
          end
          pdr_pkg::STEP_GXL: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
            mul_a   = gx_r;
            mul_b   = $signed({1'b0, dt_r[15:0]});
          end
          pdr_pkg::STEP_GXH: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b1};
            mul_a   = gx_r;
            mul_b   = $signed({1'b0, dt_r[31:16]});
          end
          pdr_pkg::STEP_GYL: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
            mul_a   = gy_r;
            mul_b   = $signed({1'b0, dt_r[15:0]});
          end
          pdr_pkg::STEP_GYH: begin
            mul_ctl = '{vld: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b1};
            mul_a   = gy_r;
            mul_b   = $signed({1'b0, dt_r[31:16]});
          end
          default: begin
            mul_ctl = '0;
          end
        endcase
      end
      pdr_pkg::ST_ACC: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept    = in_tvalid && in_tready;
  assign cor_start = accept;

  // round the scaled velocity to nanometres and add with saturation
  always_comb begin
    disp_x = pdr_pkg::DISP_W'((px_r + pdr_pkg::DISP_HALF) >>> 15);
    disp_y = pdr_pkg::DISP_W'((py_r + pdr_pkg::DISP_HALF) >>> 15);
    sum_x  = pdr_pkg::SUM_W'(pos_x_r) + pdr_pkg::SUM_W'(disp_x);
    sum_y  = pdr_pkg::SUM_W'(pos_y_r) + pdr_pkg::SUM_W'(disp_y);
    sat_x  = (sum_x > pdr_pkg::SUM_W'(pdr_pkg::POS_MAX)) ||
             (sum_x < pdr_pkg::SUM_W'(pdr_pkg::POS_MIN));
    sat_y  = (sum_y > pdr_pkg::SUM_W'(pdr_pkg::POS_MAX)) ||
             (sum_y < pdr_pkg::SUM_W'(pdr_pkg::POS_MIN));
    new_x  = sat_x ? (sum_x[pdr_pkg::SUM_W-1] ? pdr_pkg::POS_MIN : pdr_pkg::POS_MAX)
                   : pdr_pkg::POS_W'(sum_x);
    new_y  = sat_y ? (sum_y[pdr_pkg::SUM_W-1] ? pdr_pkg::POS_MIN : pdr_pkg::POS_MAX)
                   : pdr_pkg::POS_W'(sum_y);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdr_pkg::ST_IDLE;
      step_r      <= '0;
      max_step_r  <= pdr_pkg::MAX_STEP_RESET;
      last_time_r <= '0;
      started_r   <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        max_step_r <= cfg_wdata;
      end
      if (accept) begin
        last_time_r <= in_tdata[105:74];
        started_r   <= 1'b1;
      end
      if (out_load) begin
        pos_x_r     <= new_x;
        pos_y_r     <= new_y;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      roll_r  <= in_tdata[18:0];
      pitch_r <= in_tdata[37:19];
      yaw_r   <= in_tdata[56:38];
      alt_r   <= in_tdata[73:57];
      vx_r    <= $signed(in_tdata[121:106]);
      vy_r    <= $signed(in_tdata[137:122]);
      fst_r   <= in_tdata[141:138];
      // first sample after reset moves nothing
      diff_r  <= started_r ? (in_tdata[105:74] - last_time_r) : '0;
    end
    if (dt_upd) begin
      dt_r <= (diff_r > max_step_r) ? max_step_r : diff_r;
    end
    if (cap_gx) begin
      gx_r <= pdr_pkg::MUL_A_W'(mul_acc);
    end
    if (cap_gy) begin
      gy_r <= pdr_pkg::MUL_A_W'(mul_acc);
    end
    if (cap_px) begin
      px_r <= mul_acc;
    end
    if (cap_py) begin
      py_r <= mul_acc;
    end
    if (out_load) begin
      out_data_r <= {1'b0, (sat_x || sat_y), fst_r, yaw_r, pitch_r, roll_r, alt_r,
                     new_y, new_x};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // a result appears only from the accumulate step
  a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pdr_pkg::ST_ACC))
    else $error("output became valid outside the accumulate step");

  // the rotator only finishes while the sequencer waits for it
  a_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == pdr_pkg::ST_ROT))
    else $error("rotator finished outside the rotate step");

  // a saturated result leaves an accumulator pinned at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[174]) |->
      (pos_x_r == pdr_pkg::POS_MAX || pos_x_r == pdr_pkg::POS_MIN ||
       pos_y_r == pdr_pkg::POS_MAX || pos_y_r == pdr_pkg::POS_MIN))
    else $error("saturation flag without an accumulator at its bound");

  // the first sample after reset gets a zero time step
  a_first_dt: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(started_r) |-> (diff_r == '0))
    else $error("first sample got a nonzero time step");

endmodule

// ===== sv/pdr_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_cordic: iterative yaw-to-cosine/sine rotator
// Folds the angle into +/-90 degrees, runs one CORDIC iteration per cycle
// and rounds the result to Q1.15.
// ----------------------------------------------------------------------------
module pdr_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pdr_pkg::ANGLE_W-1:0]  yaw,
  output logic                                done,
  output logic signed [pdr_pkg::TRIG_W-1:0]   cos_q15,
  output logic signed [pdr_pkg::TRIG_W-1:0]   sin_q15
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [pdr_pkg::ITER_W-1:0]          cnt_r, cnt_nxt;
  logic signed [pdr_pkg::CXY_W-1:0]    x_r, x_nxt;
  logic signed [pdr_pkg::CXY_W-1:0]    y_r, y_nxt;
  logic signed [pdr_pkg::CZ_W-1:0]     z_r, z_nxt;
  logic                                neg_r, neg_nxt;
  logic signed [pdr_pkg::TRIG_W-1:0]   cos_r, cos_nxt;
  logic signed [pdr_pkg::TRIG_W-1:0]   sin_r, sin_nxt;

  logic signed [pdr_pkg::WRAP_W-1:0]   a0, a1, a2;
  logic                                fold;
  logic [pdr_pkg::ATAN_IDX_W-1:0]      idx;
  logic signed [pdr_pkg::CXY_W-1:0]    dx, dy;
  logic                                last;

  // wrap into one turn, then fold into the right half plane
  always_comb begin
    a0 = pdr_pkg::WRAP_W'(yaw);
    if (a0 >= pdr_pkg::HALF_TURN) begin
      a1 = a0 - pdr_pkg::FULL_TURN;
    end else if (a0 < -pdr_pkg::HALF_TURN) begin
      a1 = a0 + pdr_pkg::FULL_TURN;
    end else begin
      a1 = a0;
    end
    fold = 1'b1;
    if (a1 > pdr_pkg::QUARTER_TURN) begin
      a2 = a1 - pdr_pkg::HALF_TURN;
    end else if (a1 < -pdr_pkg::QUARTER_TURN) begin
      a2 = a1 + pdr_pkg::HALF_TURN;
    end else begin
      a2   = a1;
      fold = 1'b0;
    end
  end

  assign idx  = pdr_pkg::ATAN_IDX_W'(cnt_r);
  assign dx   = y_r >>> idx;
  assign dy   = x_r >>> idx;
  assign last = (cnt_r == pdr_pkg::ITER_W'(pdr_pkg::CORDIC_ITERS));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    neg_nxt  = neg_r;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = pdr_pkg::CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = $signed({a2, 12'b0});
      neg_nxt  = fold;
    end else if (busy_r && last) begin
      // round and undo the fold
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
      cos_nxt  = pdr_pkg::to_q15(neg_r ? -x_r : x_r);
      sin_nxt  = pdr_pkg::to_q15(neg_r ? -y_r : y_r);
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (!z_r[pdr_pkg::CZ_W-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - pdr_pkg::atan_lut(idx);
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + pdr_pkg::atan_lut(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  assign done    = done_r;
  assign cos_q15 = cos_r;
  assign sin_q15 = sin_r;

endmodule

// ===== sv/pdr_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_mul: shared multiply-accumulate unit
// One registered 33x17 signed multiply per cycle; the product is added to or
// subtracted from a 66-bit accumulator in the next cycle, optionally by 2^16.
// ----------------------------------------------------------------------------
module pdr_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pdr_pkg::mul_ctl_t                   ctl,
  input  logic signed [pdr_pkg::MUL_A_W-1:0]  op_a,
  input  logic signed [pdr_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [pdr_pkg::ACC_W-1:0]    acc
);

  pdr_pkg::mul_ctl_t                 ctl_r;
  logic signed [pdr_pkg::PROD_W-1:0] prod_r;
  logic signed [pdr_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [pdr_pkg::ACC_W-1:0]  ext, term;

  always_comb begin
    ext  = pdr_pkg::ACC_W'(prod_r);
    term = ctl_r.hi ? (ext <<< pdr_pkg::HALF_SH) : ext;
    if (ctl_r.neg) begin
      term = -term;
    end
    acc_nxt = acc_r;
    if (ctl_r.vld) begin
      acc_nxt = ctl_r.clr ? term : acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
